/* src/bes_pkg.sv */
`default_nettype none
package bes_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int CNT_W  = 7;   // entry count, scan pointers, result index
  localparam int IDX_W  = 6;   // entry_index field
  localparam int LINK_W = 8;   // link_value / search_key fields
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic REG_ENTRY_COUNT = 1'b0;  // register index (paddr[2])

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_OUTER,
    SEQ_INNER,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             found;
    logic [CNT_W-1:0] res_index;
  } scan_stat_t;

endpackage
`default_nettype wire

/* src/bes_link_ram.sv */
`default_nettype none
module bes_link_ram import bes_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [LINK_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [LINK_W-1:0] rd_data_r
);

  logic [LINK_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/bes_scan_seq.sv */
`default_nettype none
module bes_scan_seq import bes_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [LINK_W-1:0] key,
  input  wire logic [CNT_W-1:0]  eff_n,
  input  wire logic              take,
  output logic                   rd_en,
  output logic      [CNT_W-1:0]  rd_ptr,
  input  wire logic [LINK_W-1:0] rd_data,
  output scan_stat_t             stat
);

  seq_state_t        state_r, state_nxt;
  logic [LINK_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]  cur_i_r, cur_i_nxt;
  logic [CNT_W-1:0]  res_r, res_nxt;
  logic              found_r, found_nxt;
  logic              issue;
  logic [LINK_W-1:0] cmp_b;
  logic              hit;

  // shared compare: key during the outer scan, candidate index during the inner
  assign cmp_b  = (state_r == SEQ_INNER) ? {1'b0, cur_i_r} : key_r;
  assign hit    = rd_vld_r && (rd_data == cmp_b);
  assign issue  = (ptr_r < eff_n);
  assign rd_ptr = ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEQ_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    ptr_r    <= ptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    cur_i_r  <= cur_i_nxt;
    res_r    <= res_nxt;
    found_r  <= found_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    ptr_nxt    = ptr_r;
    rd_idx_nxt = rd_idx_r;
    rd_vld_nxt = 1'b0;
    cur_i_nxt  = cur_i_r;
    res_nxt    = res_r;
    found_nxt  = found_r;
    rd_en      = 1'b0;

    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          key_nxt   = key;
          ptr_nxt   = '0;
          state_nxt = SEQ_OUTER;
        end
      end
      SEQ_OUTER, SEQ_INNER: begin
        rd_en      = issue;
        rd_vld_nxt = issue;
        rd_idx_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = CNT_W'(ptr_r + 1'b1);
        end
        if (state_r == SEQ_OUTER) begin
          if (hit) begin
            // candidate found: drop the read in flight, scan for a backlink
            cur_i_nxt  = rd_idx_r;
            ptr_nxt    = '0;
            rd_vld_nxt = 1'b0;
            state_nxt  = SEQ_INNER;
          end else if (!rd_vld_r && !issue) begin
            res_nxt   = eff_n;
            found_nxt = 1'b0;
            state_nxt = SEQ_DONE;
          end
        end else begin
          if (hit) begin
            res_nxt    = cur_i_r;
            found_nxt  = 1'b1;
            rd_vld_nxt = 1'b0;
            state_nxt  = SEQ_DONE;
          end else if (!rd_vld_r && !issue) begin
            // no backlink: resume the outer scan after the candidate
            ptr_nxt   = CNT_W'(cur_i_r + 1'b1);
            state_nxt = SEQ_OUTER;
          end
        end
      end
      SEQ_DONE: begin
        if (take) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign stat.busy      = (state_r != SEQ_IDLE);
  assign stat.done      = (state_r == SEQ_DONE);
  assign stat.found     = found_r;
  assign stat.res_index = res_r;

endmodule
`default_nettype wire

/* src/backlinked_entry_search_core.sv */
// Write item: taken with no result; the next item may follow at once.
// Search item: the input stalls until its result loads into the output register;
// the outer scan covers the effective entry count, and each entry whose link equals
// the key starts an inner scan for a backlink.
// The scan makes one compare per cycle on the registered read port of the link RAM.
// Reset (rst_n, synchronous): sequencer idle, entry_count 0, no result; RAM kept.
`default_nettype none
module backlinked_entry_search_core import bes_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [LINK_W-1:0] in_link_value,
  input  wire logic [LINK_W-1:0] in_search_key,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CNT_W-1:0]  out_result_index,
  output logic                   out_found,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [CNT_W-1:0]  entry_count_r;
  logic [CNT_W-1:0]  eff_n;
  logic              in_xfer;
  logic              wr_en;
  logic              rd_en;
  logic [CNT_W-1:0]  rd_ptr;
  logic [LINK_W-1:0] rd_data;
  scan_stat_t        stat;
  logic              take;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_index_r;
  logic              out_found_r;

  // ---------------------------------------------------------------------------
  // Configuration: one register, entry_count, at byte address 0.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT)) begin
      entry_count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = {{(CFG_DW-CNT_W){1'b0}}, entry_count_r};
    end
  end

  // Saturate the count to the table size; it bounds both scans and is the
  // not-found answer.
  assign eff_n = (int'(entry_count_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : entry_count_r;

  // ---------------------------------------------------------------------------
  // Input side: stall while a search runs or its result waits in the
  // sequencer. A write goes straight to the RAM; an index past the table
  // is dropped.
  // ---------------------------------------------------------------------------
  assign in_stall = stat.busy;
  assign in_xfer  = in_valid && !in_stall;
  assign wr_en    = in_xfer && (in_mode == MODE_WRITE) && (int'(in_entry_index) < MAX_ENTRIES);

  bes_link_ram #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(in_entry_index)),
    .wr_data   (in_link_value),
    .rd_en     (rd_en),
    .rd_addr   (AW'(rd_ptr)),
    .rd_data_r (rd_data)
  );

  // Nested scan: the outer pass compares each link with the key, and on a
  // match the inner pass looks for any entry linking back to that index.
  bes_scan_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer && (in_mode == MODE_SEARCH)),
    .key     (in_search_key),
    .eff_n   (eff_n),
    .take    (take),
    .rd_en   (rd_en),
    .rd_ptr  (rd_ptr),
    .rd_data (rd_data),
    .stat    (stat)
  );

  // ---------------------------------------------------------------------------
  // Output register: load a finished result whenever the slot is free or
  // being transferred this cycle; hold it while stalled.
  // ---------------------------------------------------------------------------
  assign take = stat.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_index_r <= stat.res_index;
      out_found_r <= stat.found;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_found        = out_found_r;

`ifndef ASSERT_OFF
  // A found index lies inside the searched range.
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_result_index < eff_n))
    else $error("found index outside entry count");

  // A miss reports the effective count.
  a_miss_is_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_result_index == eff_n))
    else $error("miss result differs from entry count");

  // An accepted search occupies the sequencer on the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_SEARCH) |=> in_stall)
    else $error("search accepted without starting the scan");

  // A write leaves the sequencer idle.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_WRITE) |=> !in_stall)
    else $error("write item started a scan");
`endif

endmodule
`default_nettype wire

/* verif/tb_backlinked_entry_search_core.sv */
module tb_backlinked_entry_search_core;
  import bes_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int HOLD_OFF_CYCLES = 400;

  // One input transfer as the sender presents it.
  typedef struct {
    logic              mode;
    logic [IDX_W-1:0]  entry;
    logic [LINK_W-1:0] link;
    logic [LINK_W-1:0] key;
    bit                wait_drain;  // hold until every search answer is back
  } table_op_t;

  typedef struct packed {
    logic [CNT_W-1:0] idx;
    logic             found;
  } search_answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_WRITE;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [LINK_W-1:0] in_link_value = '0;
  logic [LINK_W-1:0] in_search_key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CNT_W-1:0]  out_result_index;
  logic              out_found;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Predictor state: a shadow of the link table and the entry_count register.
  logic [LINK_W-1:0] link_shadow [TABLE_DEPTH];
  logic [CNT_W-1:0]  entry_count_shadow = '0;

  // Stimulus-side knowledge of the table, used to steer keys toward hits and
  // to keep every search inside entries that have been written.
  logic [LINK_W-1:0] gen_link  [TABLE_DEPTH];
  bit                gen_known [TABLE_DEPTH];

  table_op_t      pending_ops[$];
  search_answer_t expected_answers[$];
  table_op_t      cur_op;

  int unsigned errors = 0;
  bit          send_jitter = 1'b1;
  bit          recv_jitter = 1'b1;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  backlinked_entry_search_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .in_link_value    (in_link_value),
    .in_search_key    (in_search_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_found        (out_found),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted transfer to the shadow table. A search scans entries
  // below the effective count (entry_count saturated at the table depth) for
  // the first link equal to the key whose index some entry links back to.
  // Link values at or above the depth never equal an index.
  function automatic void apply_table_op(table_op_t op);
    int n;
    int res;
    bit hit;
    if (op.mode == MODE_WRITE) begin
      link_shadow[op.entry] = op.link;
      return;
    end
    n = (entry_count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : entry_count_shadow;
    res = n;
    hit = 1'b0;
    for (int i = 0; i < n && !hit; i++) begin
      if (link_shadow[i] == op.key) begin
        for (int j = 0; j < n; j++) begin
          if (link_shadow[j] == i) begin
            hit = 1'b1;
            res = i;
            break;
          end
        end
      end
    end
    expected_answers.push_back('{idx: res[CNT_W-1:0], found: hit});
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap(bit enabled, int long_lo, int long_hi);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(long_lo, long_hi);
  endfunction

  // Driver: present the next pending transfer after the chosen gap; keep the
  // payload frozen while the block stalls.
  always @(posedge clk) begin
    bit offering;
    offering = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_table_op(cur_op);
        offering = 1'b0;
        send_gap = pick_gap(send_jitter, 10, 40);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].wait_drain && expected_answers.size() != 0)) begin
          cur_op = pending_ops.pop_front();
          offering = 1'b1;
        end
      end
      in_valid       <= offering;
      in_mode        <= cur_op.mode;
      in_entry_index <= cur_op.entry;
      in_link_value  <= cur_op.link;
      in_search_key  <= cur_op.key;
    end
  end

  // Long receiver hold-off, counted here so the block backs up its input.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result transfer against the oldest expected answer,
  // then decide whether to stall the next cycle.
  always @(posedge clk) begin
    search_answer_t exp_ans;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: index %0d found %0b", out_result_index, out_found);
        end else begin
          exp_ans = expected_answers.pop_front();
          if (out_result_index !== exp_ans.idx || out_found !== exp_ans.found) begin
            errors++;
            if (errors <= 10)
              $display("bad result: index %0d (exp %0d) found %0b (exp %0b)",
                       out_result_index, exp_ans.idx, out_found, exp_ans.found);
          end
        end
      end
      if (recv_gap > 0) recv_gap--;
      else recv_gap = pick_gap(recv_jitter, 15, 50);
      out_stall <= (hold_left != 0) || (recv_gap != 0);
    end
  end

  task automatic push_write(int entry, int link);
    pending_ops.push_back('{mode: MODE_WRITE, entry: entry[IDX_W-1:0],
                            link: link[LINK_W-1:0],
                            key: LINK_W'($urandom_range(0, 255)), wait_drain: 1'b0});
    gen_link[entry]  = link[LINK_W-1:0];
    gen_known[entry] = 1'b1;
  endtask

  task automatic push_search(int key, bit drain);
    pending_ops.push_back('{mode: MODE_SEARCH,
                            entry: IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                            link: LINK_W'($urandom_range(0, 255)), key: key[LINK_W-1:0],
                            wait_drain: drain});
  endtask

  // Settle the block: nothing queued, nothing offered, nothing outstanding,
  // then allow a trailing write to finish.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Write entry_count through the APB port: setup, then access.
  task automatic set_entry_count(int value);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ENTRY_COUNT, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    entry_count_shadow = value[CNT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random phase of `ops` transfers. Searches are held back until every entry
  // below the effective count holds a link; fill writes in the meantime do
  // not count toward `ops`. Links lean toward valid indexes so backlinks
  // exist, and keys lean toward stored links so searches hit.
  task automatic queue_random(int cfg, int ops);
    int n;
    int done;
    int hole;
    int r;
    int link;
    int key;
    n = (cfg > TABLE_DEPTH) ? TABLE_DEPTH : cfg;
    done = 0;
    while (done < ops) begin
      hole = -1;
      for (int e = n - 1; e >= 0; e--)
        if (!gen_known[e]) hole = e;
      r = $urandom_range(0, 99);
      if (r < 65) link = $urandom_range(0, (n > 0) ? n - 1 : 0);
      else if (r < 85) link = $urandom_range(0, 255);
      else begin
        case ($urandom_range(0, 3))
          0: link = 0;
          1: link = TABLE_DEPTH - 1;
          2: link = TABLE_DEPTH;
          default: link = 255;
        endcase
      end
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 3) == 0 || n == 0)
          push_write($urandom_range(0, TABLE_DEPTH - 1), link);
        else
          push_write($urandom_range(0, n - 1), link);
        done++;
      end else if (hole >= 0) begin
        push_write(hole, link);
      end else begin
        if (n > 0 && $urandom_range(0, 9) < 7) key = gen_link[$urandom_range(0, n - 1)];
        else key = $urandom_range(0, 255);
        push_search(key, $urandom_range(0, 24) == 0);
        done++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: a search answers 0, not found, even with a stored match.
    set_entry_count(0);
    push_write(0, 2);
    push_write(1, 255);
    push_write(2, 0);
    push_write(3, TABLE_DEPTH);
    push_write(4, 3);
    push_write(5, 2);
    push_write(TABLE_DEPTH - 1, 8'hAA);
    push_search(2, 1'b0);

    // Six entries, links {2,255,0,64,3,2}.
    set_entry_count(6);
    push_search(2, 1'b0);    // entry 0, linked back from entry 2
    push_search(255, 1'b0);  // matching link but no backlink: count, not found
    push_search(0, 1'b0);    // entry 2, linked back from entry 0
    push_search(TABLE_DEPTH, 1'b0);  // link beyond the table still matches a key
    push_search(3, 1'b0);    // entry 4 has no backlink
    push_search(200, 1'b0);  // no link equals the key
    push_write(5, 1);
    push_search(255, 1'b1);  // entry 1 now linked back from entry 5

    queue_random(3, 10);

    // Stretch with no idling on either side.
    set_entry_count(12);
    send_jitter = 1'b0;
    recv_jitter = 1'b0;
    queue_random(12, 10);

    // Long receiver hold-off while the sender keeps offering.
    set_entry_count(6);
    recv_jitter = 1'b1;
    queue_random(6, 18);
    @(negedge clk);
    hold_req = 1'b1;

    set_entry_count(1);
    send_jitter = 1'b1;
    queue_random(1, 8);

    // Full table, then a count beyond the table that saturates.
    set_entry_count(TABLE_DEPTH);
    queue_random(TABLE_DEPTH, 8);
    set_entry_count(127);
    queue_random(127, 6);

    set_entry_count(33);
    queue_random(33, 10);
    set_entry_count(2);
    queue_random(2, 12);

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0)
      $display("backlinked_entry_search_core: match");
    else
      $display("backlinked_entry_search_core: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #50000000;
    $display("backlinked_entry_search_core: mismatch");
    $finish;
  end

endmodule

/* backlinked_entry_search_core.f */
src/bes_pkg.sv
src/bes_link_ram.sv
src/bes_scan_seq.sv
src/backlinked_entry_search_core.sv
verif/tb_backlinked_entry_search_core.sv
